// File: rtl/tqp_pkg.sv
package tqp_pkg;

  // The default timer clock constant fits in 24 bits.
  localparam int DIVIDEND_W = 24;
  localparam int FREQ_W     = 16;
  localparam int DUR_W      = 16;
  localparam int TIME_W     = 32;
  localparam int STEP_W     = 5;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    CMD_UPDATE   = 2'd0,
    CMD_APPEND   = 2'd1,
    CMD_MELODY   = 2'd2,
    CMD_SHUTDOWN = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_ENABLED = 1'b0,
    REG_BACKEND = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_SHUTDOWN,
    OP_APPEND_WR,
    OP_CLR_PLAY,
    OP_MEL_WR,
    OP_MEL_FIN,
    OP_STOP_ACT,
    OP_IDX_ZERO,
    OP_RD_NOTE,
    OP_BEGIN,
    OP_DIV_START,
    OP_DIV_DONE,
    OP_ADV,
    OP_FINISH,
    OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_ITEM,
    CND_DISABLED,
    CND_CMD_UPD,
    CND_CMD_APP,
    CND_CMD_MEL,
    CND_QFULL,
    CND_QNONEMPTY,
    CND_LOADFULL,
    CND_NOT_LAST,
    CND_ACTIVE,
    CND_SILENT,
    CND_DIV_BUSY,
    CND_NOT_DUE,
    CND_PLAY_MORE,
    CND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic no_item;
    logic disabled;
    logic cmd_upd;
    logic cmd_app;
    logic cmd_mel;
    logic qfull;
    logic qnonempty;
    logic loadfull;
    logic not_last;
    logic active;
    logic silent;
    logic div_busy;
    logic not_due;
    logic play_more;
    logic out_busy;
  } flags_t;

  // Program entry points.
  localparam step_t S_IDLE     = 5'd0;
  localparam step_t S_APP      = 5'd6;
  localparam step_t S_APP_TAIL = 5'd10;
  localparam step_t S_MEL      = 5'd11;
  localparam step_t S_MEL_CHK  = 5'd13;
  localparam step_t S_UPD      = 5'd15;
  localparam step_t S_UPD_Q    = 5'd17;
  localparam step_t S_PLAY_1ST = 5'd18;
  localparam step_t S_NOTE     = 5'd19;
  localparam step_t S_DIV_WAIT = 5'd22;
  localparam step_t S_UPD_RUN  = 5'd24;
  localparam step_t S_OUT_WAIT = 5'd28;

  function automatic ctrl_word_t prog_word(input step_t s);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: CND_ALWAYS, target: S_IDLE};
    unique case (s)
      5'd0:  w = '{op: OP_ACCEPT,    cond: CND_NO_ITEM,   target: S_IDLE};
      5'd1:  w = '{op: OP_NOP,       cond: CND_DISABLED,  target: S_OUT_WAIT};
      5'd2:  w = '{op: OP_NOP,       cond: CND_CMD_UPD,   target: S_UPD};
      5'd3:  w = '{op: OP_NOP,       cond: CND_CMD_APP,   target: S_APP};
      5'd4:  w = '{op: OP_NOP,       cond: CND_CMD_MEL,   target: S_MEL};
      5'd5:  w = '{op: OP_SHUTDOWN,  cond: CND_ALWAYS,    target: S_OUT_WAIT};
      5'd6:  w = '{op: OP_NOP,       cond: CND_QFULL,     target: S_OUT_WAIT};
      5'd7:  w = '{op: OP_NOP,       cond: CND_QNONEMPTY, target: S_APP_TAIL};
      5'd8:  w = '{op: OP_APPEND_WR, cond: CND_NEVER,     target: S_IDLE};
      5'd9:  w = '{op: OP_CLR_PLAY,  cond: CND_ALWAYS,    target: S_PLAY_1ST};
      5'd10: w = '{op: OP_APPEND_WR, cond: CND_ALWAYS,    target: S_OUT_WAIT};
      5'd11: w = '{op: OP_NOP,       cond: CND_LOADFULL,  target: S_MEL_CHK};
      5'd12: w = '{op: OP_MEL_WR,    cond: CND_NEVER,     target: S_IDLE};
      5'd13: w = '{op: OP_NOP,       cond: CND_NOT_LAST,  target: S_OUT_WAIT};
      5'd14: w = '{op: OP_MEL_FIN,   cond: CND_NEVER,     target: S_IDLE};
      5'd15: w = '{op: OP_NOP,       cond: CND_QNONEMPTY, target: S_UPD_Q};
      5'd16: w = '{op: OP_STOP_ACT,  cond: CND_ALWAYS,    target: S_OUT_WAIT};
      5'd17: w = '{op: OP_NOP,       cond: CND_ACTIVE,    target: S_UPD_RUN};
      5'd18: w = '{op: OP_IDX_ZERO,  cond: CND_NEVER,     target: S_IDLE};
      5'd19: w = '{op: OP_RD_NOTE,   cond: CND_NEVER,     target: S_IDLE};
      5'd20: w = '{op: OP_BEGIN,     cond: CND_SILENT,    target: S_OUT_WAIT};
      5'd21: w = '{op: OP_DIV_START, cond: CND_NEVER,     target: S_IDLE};
      5'd22: w = '{op: OP_NOP,       cond: CND_DIV_BUSY,  target: S_DIV_WAIT};
      5'd23: w = '{op: OP_DIV_DONE,  cond: CND_ALWAYS,    target: S_OUT_WAIT};
      5'd24: w = '{op: OP_NOP,       cond: CND_NOT_DUE,   target: S_OUT_WAIT};
      5'd25: w = '{op: OP_ADV,       cond: CND_NEVER,     target: S_IDLE};
      5'd26: w = '{op: OP_NOP,       cond: CND_PLAY_MORE, target: S_NOTE};
      5'd27: w = '{op: OP_FINISH,    cond: CND_ALWAYS,    target: S_OUT_WAIT};
      5'd28: w = '{op: OP_NOP,       cond: CND_OUT_BUSY,  target: S_OUT_WAIT};
      5'd29: w = '{op: OP_EMIT,      cond: CND_ALWAYS,    target: S_IDLE};
      default: w = '{op: OP_NOP,     cond: CND_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/tqp_ram.sv
module tqp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tqp_div.sv
module tqp_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tqp_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [tqp_pkg::FREQ_W-1:0]      divisor,
  output logic                            busy,
  output logic [tqp_pkg::DIVIDEND_W-1:0]  quotient
);

  localparam int DVD_W = tqp_pkg::DIVIDEND_W;
  localparam int DVS_W = tqp_pkg::FREQ_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]   trial;
  logic             fits;

  // Restoring division, one quotient bit a cycle; the dividend shifts out
  // of the top of quo_r as the quotient bits shift in at the bottom.
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      dvs_nxt = divisor;
      quo_nxt = dividend;
      cnt_nxt = CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = cnt_r != '0;
  assign quotient = quo_r;

endmodule

// File: rtl/tqp_seq.sv
module tqp_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  tqp_pkg::flags_t flags,
  output tqp_pkg::op_t    op
);

  tqp_pkg::step_t      upc_r, upc_nxt;
  tqp_pkg::ctrl_word_t cw;
  logic                take;

  assign cw = tqp_pkg::prog_word(upc_r);
  assign op = cw.op;

  always_comb begin
    unique case (cw.cond)
      tqp_pkg::CND_NEVER:     take = 1'b0;
      tqp_pkg::CND_ALWAYS:    take = 1'b1;
      tqp_pkg::CND_NO_ITEM:   take = flags.no_item;
      tqp_pkg::CND_DISABLED:  take = flags.disabled;
      tqp_pkg::CND_CMD_UPD:   take = flags.cmd_upd;
      tqp_pkg::CND_CMD_APP:   take = flags.cmd_app;
      tqp_pkg::CND_CMD_MEL:   take = flags.cmd_mel;
      tqp_pkg::CND_QFULL:     take = flags.qfull;
      tqp_pkg::CND_QNONEMPTY: take = flags.qnonempty;
      tqp_pkg::CND_LOADFULL:  take = flags.loadfull;
      tqp_pkg::CND_NOT_LAST:  take = flags.not_last;
      tqp_pkg::CND_ACTIVE:    take = flags.active;
      tqp_pkg::CND_SILENT:    take = flags.silent;
      tqp_pkg::CND_DIV_BUSY:  take = flags.div_busy;
      tqp_pkg::CND_NOT_DUE:   take = flags.not_due;
      tqp_pkg::CND_PLAY_MORE: take = flags.play_more;
      tqp_pkg::CND_OUT_BUSY:  take = flags.out_busy;
      default:                take = 1'b0;
    endcase
  end

  assign upc_nxt = take ? cw.target : upc_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= tqp_pkg::S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// File: rtl/tone_queue_player.sv
// Channel  Direction  Handshake             Word
// in       input      in_valid / in_stall   cmd, now_ms, freq, length_ms, melody_last
// out      output     out_valid / out_stall divisor_load, divisor, speaker_gate,
//                                           playing, queue_count
// cfg      input      cfg_we                cfg_index, cfg_wdata (no read-back)
//
// One word is processed at a time by a microcoded step sequencer. The result sits in an
// output register, so the next input word is taken while the previous result is still
// stalled; out_stall only holds the sequencer at its output step when a new result is
// ready and the previous one has not yet left.
// Reset is synchronous and in_stall is high while it lasts; the note store needs no
// clearing pass and a word is taken from the first cycle after reset.
module tone_queue_player #(
  parameter int QUEUE_DEPTH    = 32,
  parameter int TIMER_CLOCK_HZ = 1193182
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_now_ms,
  input  logic [15:0] in_freq,
  input  logic [15:0] in_length_ms,
  input  logic        in_melody_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_divisor_load,
  output logic [15:0] out_divisor,
  output logic        out_speaker_gate,
  output logic        out_playing,
  output logic [5:0]  out_queue_count,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [0:0]  cfg_wdata
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int FREQ_W = tqp_pkg::FREQ_W;
  localparam int DUR_W  = tqp_pkg::DUR_W;
  localparam int TIME_W = tqp_pkg::TIME_W;
  localparam int DVD_W  = tqp_pkg::DIVIDEND_W;
  localparam int NOTE_W = FREQ_W + DUR_W;
  localparam logic [DVD_W-1:0] CLK_DVD = DVD_W'(TIMER_CLOCK_HZ);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  tqp_pkg::op_t    op;
  tqp_pkg::flags_t flags;

  logic              enabled_r, enabled_nxt;
  logic              backend_r, backend_nxt;
  logic [CNT_W-1:0]  qlen_r, qlen_nxt;
  logic [CNT_W-1:0]  play_idx_r, play_idx_nxt;
  logic [CNT_W-1:0]  load_idx_r, load_idx_nxt;
  logic [TIME_W-1:0] end_time_r, end_time_nxt;
  logic              active_r, active_nxt;
  logic              gate_r, gate_nxt;
  logic              res_load_r, res_load_nxt;
  logic [15:0]       res_div_r, res_div_nxt;

  tqp_pkg::cmd_t     cmd_r;
  logic [TIME_W-1:0] now_r;
  logic [FREQ_W-1:0] freq_r;
  logic [DUR_W-1:0]  dur_r;
  logic              last_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_load_r;
  logic [15:0]       out_div_r;
  logic              out_gate_r;
  logic              out_play_r;
  logic [5:0]        out_count_r;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [NOTE_W-1:0] ram_rdata;
  logic [FREQ_W-1:0] note_freq;
  logic [DUR_W-1:0]  note_dur;
  logic              div_busy;
  logic [DVD_W-1:0]  quotient;
  logic              accept;
  logic              out_free;

  assign in_stall  = !rst_n || op != tqp_pkg::OP_ACCEPT;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign note_freq = ram_rdata[NOTE_W-1:DUR_W];
  assign note_dur  = ram_rdata[DUR_W-1:0];

  assign ram_we    = op == tqp_pkg::OP_APPEND_WR || op == tqp_pkg::OP_MEL_WR;
  assign ram_waddr = (op == tqp_pkg::OP_MEL_WR) ? load_idx_r[IDX_W-1:0]
                                                : qlen_r[IDX_W-1:0];

  tqp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  tqp_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_notes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({freq_r, dur_r}),
    .re    (op == tqp_pkg::OP_RD_NOTE),
    .raddr (play_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  tqp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (op == tqp_pkg::OP_DIV_START),
    .dividend (CLK_DVD),
    .divisor  (note_freq),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    flags.no_item   = !in_valid;
    flags.disabled  = !enabled_r;
    flags.cmd_upd   = cmd_r == tqp_pkg::CMD_UPDATE;
    flags.cmd_app   = cmd_r == tqp_pkg::CMD_APPEND;
    flags.cmd_mel   = cmd_r == tqp_pkg::CMD_MELODY;
    flags.qfull     = qlen_r >= DEPTH_C;
    flags.qnonempty = qlen_r != '0;
    flags.loadfull  = load_idx_r >= DEPTH_C;
    flags.not_last  = !last_r;
    flags.active    = active_r;
    flags.silent    = backend_r || note_freq == '0;
    flags.div_busy  = div_busy;
    flags.not_due   = now_r < end_time_r;
    flags.play_more = play_idx_r < qlen_r;
    flags.out_busy  = !out_free;
  end

  always_comb begin
    enabled_nxt  = enabled_r;
    backend_nxt  = backend_r;
    qlen_nxt     = qlen_r;
    play_idx_nxt = play_idx_r;
    load_idx_nxt = load_idx_r;
    end_time_nxt = end_time_r;
    active_nxt   = active_r;
    gate_nxt     = gate_r;
    res_load_nxt = res_load_r;
    res_div_nxt  = res_div_r;
    unique case (op)
      tqp_pkg::OP_ACCEPT: begin
        res_load_nxt = 1'b0;
        res_div_nxt  = '0;
      end
      tqp_pkg::OP_SHUTDOWN: begin
        qlen_nxt     = '0;
        play_idx_nxt = '0;
        end_time_nxt = '0;
        active_nxt   = 1'b0;
        gate_nxt     = 1'b0;
        load_idx_nxt = '0;
      end
      tqp_pkg::OP_APPEND_WR: qlen_nxt = qlen_r + 1'b1;
      tqp_pkg::OP_CLR_PLAY: begin
        play_idx_nxt = '0;
        active_nxt   = 1'b0;
      end
      tqp_pkg::OP_MEL_WR: load_idx_nxt = load_idx_r + 1'b1;
      tqp_pkg::OP_MEL_FIN: begin
        qlen_nxt     = load_idx_r;
        load_idx_nxt = '0;
        play_idx_nxt = '0;
        active_nxt   = 1'b0;
      end
      tqp_pkg::OP_STOP_ACT: begin
        // An empty queue only silences a note that is still being timed.
        if (active_r) begin
          active_nxt = 1'b0;
          gate_nxt   = 1'b0;
        end
      end
      tqp_pkg::OP_IDX_ZERO: play_idx_nxt = '0;
      tqp_pkg::OP_BEGIN: begin
        end_time_nxt = now_r + TIME_W'(note_dur);
        active_nxt   = 1'b1;
        gate_nxt     = 1'b0;
      end
      tqp_pkg::OP_DIV_DONE: begin
        res_load_nxt = 1'b1;
        res_div_nxt  = (quotient == '0) ? 16'd1 : quotient[15:0];
        gate_nxt     = 1'b1;
      end
      tqp_pkg::OP_ADV: play_idx_nxt = play_idx_r + 1'b1;
      tqp_pkg::OP_FINISH: begin
        qlen_nxt     = '0;
        play_idx_nxt = '0;
        active_nxt   = 1'b0;
        gate_nxt     = 1'b0;
      end
      default: begin
      end
    endcase

    // Register writes must come only while the sequencer waits for a word; unchecked.
    if (cfg_we) begin
      unique case (tqp_pkg::cfg_reg_t'(cfg_index))
        tqp_pkg::REG_ENABLED: begin
          enabled_nxt = cfg_wdata[0];
          if (!cfg_wdata[0]) begin
            qlen_nxt     = '0;
            play_idx_nxt = '0;
            active_nxt   = 1'b0;
            gate_nxt     = 1'b0;
            load_idx_nxt = '0;
          end
        end
        tqp_pkg::REG_BACKEND: begin
          backend_nxt  = cfg_wdata[0];
          qlen_nxt     = '0;
          play_idx_nxt = '0;
          active_nxt   = 1'b0;
          gate_nxt     = 1'b0;
          load_idx_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (op == tqp_pkg::OP_EMIT) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b1;
      backend_r   <= 1'b0;
      qlen_r      <= '0;
      play_idx_r  <= '0;
      load_idx_r  <= '0;
      end_time_r  <= '0;
      active_r    <= 1'b0;
      gate_r      <= 1'b0;
      res_load_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      enabled_r   <= enabled_nxt;
      backend_r   <= backend_nxt;
      qlen_r      <= qlen_nxt;
      play_idx_r  <= play_idx_nxt;
      load_idx_r  <= load_idx_nxt;
      end_time_r  <= end_time_nxt;
      active_r    <= active_nxt;
      gate_r      <= gate_nxt;
      res_load_r  <= res_load_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_div_r <= res_div_nxt;
    if (accept) begin
      cmd_r  <= tqp_pkg::cmd_t'(in_cmd);
      now_r  <= in_now_ms;
      freq_r <= in_freq;
      dur_r  <= in_length_ms;
      last_r <= in_melody_last;
    end
    if (op == tqp_pkg::OP_EMIT) begin
      out_load_r  <= res_load_r;
      out_div_r   <= res_div_r;
      out_gate_r  <= gate_r;
      out_play_r  <= active_r;
      out_count_r <= 6'(qlen_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_divisor_load = out_load_r;
  assign out_divisor      = out_div_r;
  assign out_speaker_gate = out_gate_r;
  assign out_playing      = out_play_r;
  assign out_queue_count  = out_count_r;

endmodule

// File: rtl/tqp_chk.sv
module tqp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_divisor_load,
  input logic [15:0] out_divisor,
  input logic        out_speaker_gate,
  input logic        out_playing
);

  // Only one word is in flight: the input closes right after taking one.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input word taken while another is being processed");

  // A programmed divisor always comes with a sounding, timed note.
  a_load_sounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divisor_load |-> out_speaker_gate && out_playing)
    else $error("divisor programmed without gate and playback");

  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_divisor_load |-> out_divisor == 16'd0)
    else $error("divisor shown without a divisor load");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_divisor))
    else $error("stalled result word changed or dropped");

endmodule

bind tone_queue_player tqp_chk u_tqp_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_divisor_load (out_divisor_load),
  .out_divisor      (out_divisor),
  .out_speaker_gate (out_speaker_gate),
  .out_playing      (out_playing)
);

// File: test/tb_tone_queue_player.sv
`timescale 1ns / 1ps

module tb_tone_queue_player;

  localparam int unsigned QDEPTH   = 32;
  localparam int unsigned TIMER_HZ = 1193182;
  localparam int unsigned QUIET_LIMIT = 3000;

  typedef struct packed {
    tqp_pkg::cmd_t cmd;
    logic [31:0]   now;
    logic [15:0]   hz;
    logic [15:0]   len;
    logic          last;
  } tone_word_t;

  typedef struct packed {
    logic        load;
    logic [15:0] div;
    logic        gate;
    logic        play;
    logic [5:0]  count;
  } tone_result_t;

  typedef struct packed {
    tone_word_t   w;
    logic         typed;
    tone_result_t res;
  } tone_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = '0;
  logic [31:0] in_now_ms = '0;
  logic [15:0] in_freq = '0;
  logic [15:0] in_length_ms = '0;
  logic        in_melody_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_divisor_load;
  logic [15:0] out_divisor;
  logic        out_speaker_gate;
  logic        out_playing;
  logic [5:0]  out_queue_count;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [0:0]  cfg_wdata = '0;

  // A word sent from the directed table may carry its result typed in.
  logic         typed_on = 1'b0;
  tone_result_t typed_res = '0;

  always #5 clk = ~clk;

  tone_queue_player dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_now_ms(in_now_ms),
    .in_freq(in_freq), .in_length_ms(in_length_ms), .in_melody_last(in_melody_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_divisor_load(out_divisor_load),
    .out_divisor(out_divisor), .out_speaker_gate(out_speaker_gate),
    .out_playing(out_playing), .out_queue_count(out_queue_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Player state as the predictor sees it.
  logic [15:0] note_hz [QDEPTH];
  logic [15:0] note_len [QDEPTH];
  int unsigned q_len = 0;
  int unsigned play_pos = 0;
  int unsigned load_pos = 0;
  logic [31:0] note_end = '0;
  bit          timing = 1'b0;
  bit          gate_on = 1'b0;
  bit          snd_en = 1'b1;
  bit          silent_be = 1'b0;
  bit          res_load;
  logic [15:0] res_div;

  tone_result_t awaited_results[$];
  int unsigned  checked = 0;
  int unsigned  bad_results = 0;
  int unsigned  words_sent = 0;
  int unsigned  loads_seen = 0;
  int unsigned  full_drops = 0;
  int unsigned  mel_drops = 0;
  int unsigned  quiet = 0;
  int unsigned  stall_left = 0;
  bit           calm = 1'b0;
  logic [31:0]  clock_ms = 32'd5000;

  function automatic void start_note(int unsigned idx, logic [31:0] now);
    logic [15:0] f;
    int unsigned q;
    f = note_hz[idx];
    if (silent_be || f == 16'd0) begin
      gate_on = 1'b0;
    end else begin
      q = TIMER_HZ / f;
      if (q == 0) q = 1;
      res_load = 1'b1;
      res_div = q[15:0];
      gate_on = 1'b1;
      loads_seen++;
    end
    note_end = now + note_len[idx];
    timing = 1'b1;
  endfunction

  function automatic void advance(logic [31:0] now);
    if (q_len == 0) begin
      if (timing) begin
        gate_on = 1'b0;
        timing = 1'b0;
      end
      return;
    end
    if (!timing) begin
      play_pos = 0;
      start_note(0, now);
      return;
    end
    // Plain unsigned compare: a wrapped end time lets the note end at once.
    if (now >= note_end) begin
      play_pos++;
      if (play_pos >= q_len) begin
        q_len = 0;
        play_pos = 0;
        timing = 1'b0;
        gate_on = 1'b0;
        return;
      end
      start_note(play_pos, now);
    end
  endfunction

  function automatic void clear_queue();
    q_len = 0;
    play_pos = 0;
    timing = 1'b0;
    gate_on = 1'b0;
    load_pos = 0;
  endfunction

  function automatic void apply_reg(tqp_pkg::cfg_reg_t idx, bit val);
    if (idx == tqp_pkg::REG_ENABLED) begin
      snd_en = val;
      if (!val) clear_queue();
    end else begin
      silent_be = val;
      clear_queue();
    end
  endfunction

  function automatic tone_result_t next_result(tone_word_t w);
    tone_result_t r;
    res_load = 1'b0;
    res_div = '0;
    if (snd_en) begin
      case (w.cmd)
        tqp_pkg::CMD_UPDATE: advance(w.now);
        tqp_pkg::CMD_APPEND: begin
          if (q_len >= QDEPTH) begin
            full_drops++;
          end else if (q_len == 0) begin
            note_hz[0] = w.hz;
            note_len[0] = w.len;
            q_len = 1;
            play_pos = 0;
            timing = 1'b0;
            advance(w.now);
          end else begin
            note_hz[q_len] = w.hz;
            note_len[q_len] = w.len;
            q_len++;
          end
        end
        tqp_pkg::CMD_MELODY: begin
          if (load_pos < QDEPTH) begin
            note_hz[load_pos] = w.hz;
            note_len[load_pos] = w.len;
            load_pos++;
          end else begin
            mel_drops++;
          end
          if (w.last) begin
            q_len = load_pos;
            load_pos = 0;
            play_pos = 0;
            timing = 1'b0;
            advance(w.now);
          end
        end
        default: begin
          clear_queue();
          note_end = '0;
        end
      endcase
    end
    r.load = res_load;
    r.div = res_div;
    r.gate = gate_on;
    r.play = timing;
    r.count = 6'(q_len);
    return r;
  endfunction

  function automatic string fmt(tone_result_t r);
    return $sformatf("load=%0d div=%0d gate=%0d play=%0d count=%0d",
                     r.load, r.div, r.gate, r.play, r.count);
  endfunction

  function automatic tone_word_t mk_word(tqp_pkg::cmd_t c, logic [31:0] now,
                                         logic [15:0] hz, logic [15:0] len, logic last);
    tone_word_t w;
    w.cmd = c;
    w.now = now;
    w.hz = hz;
    w.len = len;
    w.last = last;
    return w;
  endfunction

  function automatic tone_row_t row(tone_word_t w, logic typed, tone_result_t res);
    tone_row_t r;
    r.w = w;
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  // Time mostly creeps forward; now and then it jumps, sometimes to just short of the wrap.
  function automatic logic [31:0] tick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) clock_ms = $urandom;
    else if (r < 4) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 60);
    else clock_ms = clock_ms + $urandom_range(0, 25);
    return clock_ms;
  endfunction

  function automatic logic [15:0] pick_hz();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'($urandom_range(1, 20));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 18) return 16'($urandom);
    return 16'($urandom_range(1, 40));
  endfunction

  always @(posedge clk) begin : monitor
    tone_result_t got;
    tone_result_t want;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got = {out_divisor_load, out_divisor, out_speaker_gate, out_playing, out_queue_count};
        if (awaited_results.size() == 0) begin
          bad_results++;
          if (bad_results <= 10) $display("%0t: result with none awaited: %s", $time, fmt(got));
        end else begin
          want = awaited_results.pop_front();
          checked++;
          if (got.load !== want.load || got.div !== want.div || got.gate !== want.gate ||
              got.play !== want.play || got.count !== want.count) begin
            bad_results++;
            if (bad_results <= 10)
              $display("%0t: mismatch\n  expected %s\n  actual   %s", $time, fmt(want), fmt(got));
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        want = next_result(mk_word(tqp_pkg::cmd_t'(in_cmd), in_now_ms, in_freq, in_length_ms,
                                   in_melody_last));
        if (typed_on) want = typed_res;
        awaited_results.push_back(want);
      end
      if (moved || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_tone_queue_player failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) stall_left--;
    else if (rst_n && !calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
    out_stall <= (stall_left != 0);
  end

  task automatic send_word(input tone_word_t w, input logic typed, input tone_result_t res);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= w.cmd;
    in_now_ms <= w.now;
    in_freq <= w.hz;
    in_length_ms <= w.len;
    in_melody_last <= w.last;
    typed_on <= typed;
    typed_res <= res;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_live(input tqp_pkg::cmd_t c, input logic [15:0] hz,
                           input logic [15:0] len, input logic last);
    send_word(mk_word(c, tick(), hz, len, last), 1'b0, '0);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_words(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned k;
    int unsigned i;
    bit broken;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_live(tqp_pkg::CMD_UPDATE, 16'($urandom), 16'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 55) begin
        send_live(tqp_pkg::CMD_APPEND, pick_hz(), pick_len(), 1'($urandom));
        sent++;
      end else if (pick < 62) begin
        // A run of 30 to 36 appends, which can hit a full queue.
        k = $urandom_range(30, 36);
        repeat (k) send_live(tqp_pkg::CMD_APPEND, pick_hz(), pick_len(), 1'($urandom));
        sent += k;
      end else if (pick < 76) begin
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
        broken = ($urandom_range(0, 9) == 0);
        for (i = 0; i < k; i++)
          send_live(tqp_pkg::CMD_MELODY, pick_hz(), pick_len(), (i == k - 1) && !broken);
        sent += k;
      end else if (pick < 81) begin
        send_live(tqp_pkg::CMD_SHUTDOWN, 16'($urandom), 16'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 86) begin
        clock_ms = $urandom;
        send_word(mk_word(tqp_pkg::cmd_t'(2'($urandom_range(0, 3))), clock_ms,
                          16'($urandom), 16'($urandom), 1'($urandom)), 1'b0, '0);
        sent++;
      end else begin
        k = $urandom_range(3, 10);
        repeat (k) send_live(tqp_pkg::CMD_UPDATE, 16'($urandom), 16'($urandom), 1'b0);
        sent += k;
      end
    end
  endtask

  task automatic run_phase(input bit w_en, input bit en, input bit w_be, input bit be,
                           input int unsigned n);
    drain_block();
    if (w_en) begin
      cfg_we <= 1'b1;
      cfg_index <= tqp_pkg::REG_ENABLED;
      cfg_wdata <= en;
      @(posedge clk);
      apply_reg(tqp_pkg::REG_ENABLED, en);
    end
    if (w_be) begin
      cfg_we <= 1'b1;
      cfg_index <= tqp_pkg::REG_BACKEND;
      cfg_wdata <= be;
      @(posedge clk);
      apply_reg(tqp_pkg::REG_BACKEND, be);
    end
    cfg_we <= 1'b0;
    run_words(n);
  endtask

  initial begin : stimulus
    tone_row_t steps[$];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    steps.push_back(row(mk_word(tqp_pkg::CMD_UPDATE, 32'd0, 16'd0, 16'd0, 1'b0), 1'b1, '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_APPEND, 32'd0, 16'd1, 16'd0, 1'b0), 1'b1,
                        {1'b1, 16'd13534, 1'b1, 1'b1, 6'd1}));
    steps.push_back(row(mk_word(tqp_pkg::CMD_UPDATE, 32'd0, 16'd0, 16'd0, 1'b0), 1'b1, '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_APPEND, 32'd100, 16'd0, 16'hFFFF, 1'b0), 1'b1,
                        {1'b0, 16'd0, 1'b0, 1'b1, 6'd1}));
    steps.push_back(row(mk_word(tqp_pkg::CMD_APPEND, 32'd101, 16'hFFFF, 16'd10, 1'b0), 1'b0,
                        '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_UPDATE, 32'd200, 16'd0, 16'd0, 1'b0), 1'b0, '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_UPDATE, 32'd65635, 16'd0, 16'd0, 1'b0), 1'b0,
                        '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_UPDATE, 32'hFFFF_FFF0, 16'd0, 16'd0, 1'b0), 1'b0,
                        '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_APPEND, 32'hFFFF_FFF8, 16'd440, 16'd20, 1'b0),
                        1'b0, '0));
    // The end time has wrapped past zero, so this update finishes the note early.
    steps.push_back(row(mk_word(tqp_pkg::CMD_UPDATE, 32'hFFFF_FFFA, 16'd0, 16'd0, 1'b0), 1'b0,
                        '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_MELODY, 32'd1000, 16'd262, 16'd5, 1'b0), 1'b0,
                        '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_MELODY, 32'd1001, 16'd0, 16'd5, 1'b0), 1'b0,
                        '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_MELODY, 32'd1002, 16'hFFFF, 16'hFFFF, 1'b1),
                        1'b0, '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_UPDATE, 32'd1007, 16'd0, 16'd0, 1'b0), 1'b0,
                        '0));
    // A new melody load overwrites entries that are still being played.
    steps.push_back(row(mk_word(tqp_pkg::CMD_MELODY, 32'd1008, 16'd1000, 16'd1, 1'b0), 1'b0,
                        '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_SHUTDOWN, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                                1'b1), 1'b1, '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_MELODY, 32'd2000, 16'd500, 16'd3, 1'b1), 1'b0,
                        '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_APPEND, 32'd2001, 16'd30000, 16'd0, 1'b0), 1'b0,
                        '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_UPDATE, 32'd2003, 16'd0, 16'd0, 1'b0), 1'b0,
                        '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_UPDATE, 32'd2003, 16'd0, 16'd0, 1'b0), 1'b0,
                        '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_UPDATE, 32'd2004, 16'd0, 16'd0, 1'b0), 1'b1,
                        '0));
    steps.push_back(row(mk_word(tqp_pkg::CMD_MELODY, 32'd0, 16'd1, 16'd0, 1'b1), 1'b0, '0));
    foreach (steps[i]) send_word(steps[i].w, steps[i].typed, steps[i].res);

    run_phase(1'b1, 1'b1, 1'b1, 1'b0, 350);
    run_phase(1'b0, 1'b0, 1'b1, 1'b1, 200);
    run_phase(1'b1, 1'b0, 1'b0, 1'b0, 30);
    run_phase(1'b1, 1'b1, 1'b0, 1'b0, 120);
    run_phase(1'b0, 1'b0, 1'b1, 1'b0, 220);
    // Enabling an already enabled player must leave a playing queue alone.
    run_phase(1'b1, 1'b1, 1'b0, 1'b0, 120);
    run_phase(1'b1, 1'b0, 1'b1, 1'b0, 25);
    calm = 1'b1;
    run_phase(1'b1, 1'b1, 1'b1, 1'b0, 250);

    drain_block();
    repeat (60) @(posedge clk);
    $display("Sent %0d words and checked %0d results, %0d of them loading a divisor.",
             words_sent, checked, loads_seen);
    $display("Appends dropped on a full queue: %0d; melody notes dropped past the end: %0d.",
             full_drops, mel_drops);
    if (bad_results == 0) $display("tb_tone_queue_player passed");
    else $display("tb_tone_queue_player failed");
    $finish;
  end

endmodule
